// ===== rtl/core/rgb_decimal_triplet_parser_defines.svh =====
// assertion macros for the rgb triplet parser
// no dependencies; included by files that carry concurrent checks
`ifndef RGB_DECIMAL_TRIPLET_PARSER_DEFINES_SVH
`define RGB_DECIMAL_TRIPLET_PARSER_DEFINES_SVH
`ifndef SYNTHESIS
`define RDTP_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("rdtp check failed");
`define RDTP_ASSERT_NEVER(label, clk, rst_n, cond) \
	`RDTP_ASSERT(label, clk, rst_n, !(cond))
`else
`define RDTP_ASSERT(label, clk, rst_n, prop)
`define RDTP_ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

// ===== rtl/core/rdtp_pkg.sv =====
// shared types and constants for the rgb triplet parser
// no dependencies
package rdtp_pkg;
	localparam logic [7:0] CHAR_NUL   = 8'h00;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_TAB   = 8'h09;
	localparam logic [7:0] CHAR_COMMA = 8'h2C;
	localparam logic [7:0] CHAR_PLUS  = 8'h2B;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;
	localparam logic [7:0] ALPHA      = 8'hFF;
	localparam logic [11:0] BYTE_MAX  = 12'd255;

	localparam logic [1:0] SUB_BLANK_PRE  = 2'd0;
	localparam logic [1:0] SUB_SIGN       = 2'd1;
	localparam logic [1:0] SUB_DIGITS     = 2'd2;
	localparam logic [1:0] SUB_BLANK_POST = 2'd3;

	localparam logic [1:0] FIELD_RED   = 2'd0;
	localparam logic [1:0] FIELD_GREEN = 2'd1;
	localparam logic [1:0] FIELD_BLUE  = 2'd2;
	localparam logic [1:0] FIELD_NONE  = 2'd3;

	typedef struct packed {
		logic        valid_res;
		logic [31:0] color;
	} rdtp_result_t;
endpackage

// ===== rtl/core/rdtp_char_if.sv =====
// character channel: valid/ready handshake with one text byte
// no dependencies
interface rdtp_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;

	modport source (output valid, output char_code, input ready);
	modport sink (input valid, input char_code, output ready);
endinterface

// ===== rtl/core/rdtp_color_if.sv =====
// result channel: valid/ready handshake with the parse result
// no dependencies
interface rdtp_color_if;
	logic        valid;
	logic        ready;
	logic        valid_res;
	logic [31:0] color;

	modport source (output valid, output valid_res, output color, input ready);
	modport sink (input valid, input valid_res, input color, output ready);
endinterface

// ===== rtl/core/rdtp_fsm.sv =====
// parse state registers and next-state logic for one character per cycle while step is high
// depends on rdtp_pkg
module rdtp_fsm import rdtp_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         step,
	input  logic [7:0]   char_code,
	output logic         res_fire,
	output rdtp_result_t res
);
	logic [3:0]  phase_q, phase_d;
	logic [7:0]  acc_q, acc_d;
	logic [7:0]  red_q, red_d;
	logic [7:0]  green_q, green_d;
	logic        failed_q, failed_d;
	logic [1:0]  field, sub;
	logic        is_nul, is_blank, is_digit, is_comma, is_plus;
	logic [7:0]  dig_base;
	logic [11:0] dig_sum;
	logic        dig_over;
	logic        line_ok;

	assign field    = phase_q[3:2];
	assign sub      = phase_q[1:0];
	assign is_nul   = (char_code == CHAR_NUL);
	assign is_blank = (char_code == CHAR_SPACE) || (char_code == CHAR_TAB);
	assign is_digit = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
	assign is_comma = (char_code == CHAR_COMMA);
	assign is_plus  = (char_code == CHAR_PLUS);

	// first digit of a value starts from zero
	assign dig_base = (sub == SUB_DIGITS) ? acc_q : 8'd0;
	assign dig_sum  = {4'd0, dig_base} * 12'd10 + {8'd0, char_code[3:0]};
	assign dig_over = (dig_sum > BYTE_MAX);

	assign line_ok = !failed_q && (field == FIELD_BLUE)
		&& ((sub == SUB_DIGITS) || (sub == SUB_BLANK_POST));

	assign res_fire        = step && is_nul;
	assign res.valid_res   = line_ok;
	assign res.color       = line_ok ? {ALPHA, acc_q, green_q, red_q} : 32'd0;

	always_comb begin
		phase_d  = phase_q;
		acc_d    = acc_q;
		red_d    = red_q;
		green_d  = green_q;
		failed_d = failed_q;
		if (step) begin
			if (is_nul) begin
				phase_d  = {FIELD_RED, SUB_BLANK_PRE};
				acc_d    = 8'd0;
				red_d    = 8'd0;
				green_d  = 8'd0;
				failed_d = 1'b0;
			end else if (!failed_q) begin
				if (field == FIELD_NONE) begin
					failed_d = 1'b1;
				end else begin
					unique case (sub)
						SUB_BLANK_PRE, SUB_SIGN: begin
							if (is_blank && sub == SUB_BLANK_PRE) begin
								phase_d = phase_q;
							end else if (is_plus && sub == SUB_BLANK_PRE) begin
								phase_d = {field, SUB_SIGN};
							end else if (is_digit) begin
								if (dig_over) begin
									failed_d = 1'b1;
								end else begin
									acc_d = dig_sum[7:0];
								end
								phase_d = {field, SUB_DIGITS};
							end else begin
								failed_d = 1'b1;
							end
						end
						SUB_DIGITS, SUB_BLANK_POST: begin
							if (is_digit && sub == SUB_DIGITS) begin
								if (dig_over) begin
									failed_d = 1'b1;
								end else begin
									acc_d = dig_sum[7:0];
								end
							end else if (is_blank) begin
								phase_d = {field, SUB_BLANK_POST};
							end else if (is_comma) begin
								// close a red or green field and move to the next one; a comma after blue fails the line
								priority if (field == FIELD_RED) begin
									red_d   = acc_q;
									acc_d   = 8'd0;
									phase_d = {FIELD_GREEN, SUB_BLANK_PRE};
								end else if (field == FIELD_GREEN) begin
									green_d = acc_q;
									acc_d   = 8'd0;
									phase_d = {FIELD_BLUE, SUB_BLANK_PRE};
								end else begin
									failed_d = 1'b1;
								end
							end else begin
								failed_d = 1'b1;
							end
						end
						default: failed_d = 1'b1;
					endcase
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= {FIELD_RED, SUB_BLANK_PRE};
			acc_q    <= 8'd0;
			red_q    <= 8'd0;
			green_q  <= 8'd0;
			failed_q <= 1'b0;
		end else begin
			phase_q  <= phase_d;
			acc_q    <= acc_d;
			red_q    <= red_d;
			green_q  <= green_d;
			failed_q <= failed_d;
		end
	end
endmodule

// ===== rtl/core/rdtp_out_reg.sv =====
// result register driving the output channel
// depends on rdtp_pkg and rdtp_color_if
module rdtp_out_reg import rdtp_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         load,
	input  rdtp_result_t res,
	output logic         busy,
	rdtp_color_if.source color_out
);
	logic         out_valid_q;
	rdtp_result_t res_q;

	// slot counts as busy only when held and not drained this cycle
	assign busy = out_valid_q && !color_out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (color_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign color_out.valid     = out_valid_q;
	assign color_out.valid_res = res_q.valid_res;
	assign color_out.color     = res_q.color;
endmodule

// ===== rtl/core/rgb_decimal_triplet_parser.sv =====
// a NUL's result goes from the input stage register into the result register, which drives color_out
// throughput: one character per cycle; only a NUL waits, while the result register is full
//   and not being drained in the same cycle
// reset: arst_n clears the input stage, the parse state and the result valid at once
// top level of the rgb triplet parser
// depends on rdtp_pkg, rdtp_char_if, rdtp_color_if, rdtp_fsm, rdtp_out_reg
`include "rgb_decimal_triplet_parser_defines.svh"
module rgb_decimal_triplet_parser import rdtp_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	rdtp_char_if.sink    char_in,
	rdtp_color_if.source color_out
);
	// input stage
	logic         valid_s1;
	logic [7:0]   char_s1;
	logic         nul_s1;
	logic         step;
	logic         out_busy;
	logic         res_fire;
	rdtp_result_t res;
	// result shown on the output, split by its verdict
	logic         out_good;
	logic         out_bad;

	assign nul_s1 = (char_s1 == CHAR_NUL);

	// a plain character always advances; a nul needs a free result slot
	assign step = valid_s1 && (!nul_s1 || !out_busy);

	// take a new character whenever the input stage empties this cycle
	assign char_in.ready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (char_in.ready) begin
			valid_s1 <= char_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (char_in.valid && char_in.ready) begin
			char_s1 <= char_in.char_code;
		end
	end

	// parse state and next-state logic
	rdtp_fsm u_fsm (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.char_code (char_s1),
		.res_fire  (res_fire),
		.res       (res)
	);

	// result register, one line result at a time
	rdtp_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (res_fire),
		.res       (res),
		.busy      (out_busy),
		.color_out (color_out)
	);

	assign out_good = color_out.valid && color_out.valid_res;
	assign out_bad  = color_out.valid && !color_out.valid_res;

	// a rejected line always reports an all-zero word
	`RDTP_ASSERT_NEVER(a_invalid_zero, clk, arst_n, out_bad && color_out.color != 32'd0)
	// a good line always carries the opaque alpha byte
	`RDTP_ASSERT(a_alpha_set, clk, arst_n, out_good |-> color_out.color[31:24] == ALPHA)
	// every nul leaving the input stage shows up as a result next cycle
	`RDTP_ASSERT(a_nul_result, clk, arst_n, step && nul_s1 |=> color_out.valid)
	// a nul never leaves the input stage while a result is still held
	`RDTP_ASSERT_NEVER(a_no_overwrite, clk, arst_n, res_fire && out_busy)
endmodule
